[hw/rtl/bsd_pkg.sv]
// bsd_pkg: types, codes and constants shared by the 24-bit bitmap stream decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DIM_OUT_W = 13;

   // file signature
   localparam logic [BYTE_W-1:0] SIG_FIRST  = 8'h42;
   localparam logic [BYTE_W-1:0] SIG_SECOND = 8'h4D;

   // header byte offsets
   localparam int unsigned HPOS_W = 6;
   localparam logic [HPOS_W-1:0] SIG_FIRST_POS  = 6'd0;
   localparam logic [HPOS_W-1:0] SIG_SECOND_POS = 6'd1;
   localparam logic [HPOS_W-1:0] WIDTH_POS      = 6'd18;
   localparam logic [HPOS_W-1:0] HEIGHT_POS     = 6'd22;
   localparam logic [HPOS_W-1:0] HEIGHT_END     = 6'd26;
   localparam logic [HPOS_W-1:0] HDR_LAST_POS   = 6'd53;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PIXELS,
      PH_PAD,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL    = 2'd0,
      KIND_HEADER   = 2'd1,
      KIND_NOT_BMP  = 2'd2,
      KIND_OVERSIZE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_of_file;
   } req_item_type;

   typedef struct packed {
      kind_type             kind;
      logic [BYTE_W-1:0]    red;
      logic [BYTE_W-1:0]    green;
      logic [BYTE_W-1:0]    blue;
      logic [DIM_OUT_W-1:0] image_width;
      logic [DIM_OUT_W-1:0] image_height;
      logic                 last_pixel;
   } rsp_item_type;

   // pipeline advance handshake between stages
   typedef struct packed {
      logic advance;
      logic step;
   } pipe_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/bsd_in_reg.sv]
// bsd_in_reg: input register of the bitmap stream decoder
// depends on bsd_pkg for the input item type
`timescale 1ns / 1ps
`default_nettype none

module bsd_in_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  wire                   advance,
   input  bsd_pkg::req_item_type item,
   output logic                  valid,
   output bsd_pkg::req_item_type held
);
   import bsd_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign valid = valid_ff;
   assign held  = item_ff;

endmodule

`default_nettype wire

[hw/rtl/bsd_parser.sv]
// bsd_parser: file state and per-byte decoding of header, pixels and row padding
// depends on bsd_pkg for phases, result kinds and header offsets
`timescale 1ns / 1ps
`default_nettype none

module bsd_parser #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire                   clock,
   input  wire                   reset,
   input  bsd_pkg::pipe_ctl_type ctl,
   input  bsd_pkg::req_item_type item,
   output logic                  res_valid,
   output bsd_pkg::rsp_item_type res
);
   import bsd_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

   phase_type          phase_ff, phase_in, phase_e;
   logic [HPOS_W-1:0]  hpos_ff, hpos_in, hpos_e;
   logic [31:0]        width_ff, width_in, width_e;
   logic [31:0]        height_ff, height_in, height_e;
   logic [DIM_W-1:0]   col_ff, col_in, col_next;
   logic [DIM_W-1:0]   row_ff, row_in, row_next;
   logic [1:0]         bip_ff, bip_in;
   logic [1:0]         pad_ff, pad_in, pad_dec;
   logic [BYTE_W-1:0]  blue_ff, blue_in;
   logic [BYTE_W-1:0]  green_ff, green_in;
   logic [HPOS_W-1:0]  wlane_sum, hlane_sum;
   logic [BYTE_W-1:0]  b;
   logic               sig_bad, dim_bad;

   assign b = item.data_byte;

   // a start byte restarts the file at offset zero with cleared words
   always_comb begin
      phase_e  = item.first_of_file ? PH_HEADER : phase_ff;
      hpos_e   = item.first_of_file ? '0 : hpos_ff;
      width_e  = item.first_of_file ? '0 : width_ff;
      height_e = item.first_of_file ? '0 : height_ff;
   end

   always_comb begin
      wlane_sum = hpos_e - WIDTH_POS;
      hlane_sum = hpos_e - HEIGHT_POS;
      sig_bad   = (hpos_e == SIG_FIRST_POS && b != SIG_FIRST)
               || (hpos_e == SIG_SECOND_POS && b != SIG_SECOND);
      dim_bad   = width_e == '0 || width_e > 32'(MAX_DIM)
               || height_e == '0 || height_e > 32'(MAX_DIM);
      col_next  = col_ff + DIM_W'(1);
      row_next  = row_ff + DIM_W'(1);
      pad_dec   = pad_ff - {1'b0, pad_ff != 2'd0};
   end

   always_comb begin
      phase_in  = phase_e;
      hpos_in   = hpos_e;
      width_in  = width_e;
      height_in = height_e;
      col_in    = item.first_of_file ? '0 : col_ff;
      row_in    = item.first_of_file ? '0 : row_ff;
      bip_in    = item.first_of_file ? '0 : bip_ff;
      pad_in    = item.first_of_file ? '0 : pad_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      res_valid = 1'b0;
      res       = '0;
      unique case (phase_e)
         PH_HEADER: begin
            if (sig_bad) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.kind  = KIND_NOT_BMP;
            end else begin
               if (hpos_e >= WIDTH_POS && hpos_e < HEIGHT_POS) begin
                  width_in[8*wlane_sum[1:0] +: 8] = b;
               end else if (hpos_e >= HEIGHT_POS && hpos_e < HEIGHT_END) begin
                  height_in[8*hlane_sum[1:0] +: 8] = b;
               end
               if (hpos_e != HDR_LAST_POS) begin
                  hpos_in = hpos_e + HPOS_W'(1);
               end else if (dim_bad) begin
                  phase_in  = PH_DONE;
                  res_valid = 1'b1;
                  res.kind  = KIND_OVERSIZE;
               end else begin
                  phase_in         = PH_PIXELS;
                  col_in           = '0;
                  row_in           = '0;
                  bip_in           = '0;
                  res_valid        = 1'b1;
                  res.kind         = KIND_HEADER;
                  res.image_width  = width_e[DIM_OUT_W-1:0];
                  res.image_height = height_e[DIM_OUT_W-1:0];
               end
            end
         end
         PH_PIXELS: begin
            if (bip_ff == 2'd0) begin
               blue_in = b;
               bip_in  = 2'd1;
            end else if (bip_ff == 2'd1) begin
               green_in = b;
               bip_in   = 2'd2;
            end else begin
               bip_in    = 2'd0;
               res_valid = 1'b1;
               res.kind  = KIND_PIXEL;
               res.red   = b;
               res.green = green_ff;
               res.blue  = blue_ff;
               // dimensions were checked against the limit, so they fit the counters
               if (col_next >= width_e[DIM_W-1:0]) begin
                  col_in = '0;
                  row_in = row_next;
                  pad_in = width_e[1:0];
                  if (row_next >= height_e[DIM_W-1:0]) begin
                     res.last_pixel = 1'b1;
                     phase_in       = PH_DONE;
                  end else if (width_e[1:0] != 2'd0) begin
                     phase_in = PH_PAD;
                  end
               end else begin
                  col_in = col_next;
               end
            end
         end
         PH_PAD: begin
            pad_in = pad_dec;
            if (pad_dec == 2'd0) begin
               phase_in = PH_PIXELS;
            end
         end
         PH_IDLE, PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hpos_ff   <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         bip_ff    <= '0;
         pad_ff    <= '0;
      end else if (ctl.step) begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         bip_ff    <= bip_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bsd_out_reg.sv]
// bsd_out_reg: result register that holds a beat until the consumer takes it
// depends on bsd_pkg for the result item type
`timescale 1ns / 1ps
`default_nettype none

module bsd_out_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   ready,
   input  bsd_pkg::pipe_ctl_type ctl,
   input  wire                   res_valid,
   input  bsd_pkg::rsp_item_type res,
   output logic                  valid,
   output logic                  advance,
   output bsd_pkg::rsp_item_type held
);
   import bsd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type res_ff;

   // the register frees up when empty or when its beat is taken this cycle
   assign advance = !valid_ff || ready;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.advance) begin
         valid_in = ctl.step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step && res_valid) begin
         res_ff <= res;
      end
   end

   assign valid = valid_ff;
   assign held  = res_ff;

endmodule

`default_nettype wire

[hw/rtl/bmp24_stream_decoder_unit.sv]
// channel  dir  signals                          beat holds
// req      in   req_tvalid/tready/tdata/tuser    one file byte, start-of-file flag
// rsp      out  rsp_tvalid/tready/tdata/tuser/   pixel, header or error report
//                tlast
//
// one byte per clock when the consumer keeps up; each byte waits in the input
// register while the parser decodes it, and its result goes to the result register.
// a byte that completes no pixel or header and finds no error yields no beat. a held
// result stalls both registers, so at most one byte waits. reset is synchronous and
// returns the decoder to idle; bytes are ignored until one arrives with the start flag.
//
// bmp24_stream_decoder_unit: top level of the 24-bit uncompressed bitmap decoder
// depends on bsd_pkg, bsd_in_reg, bsd_parser and bsd_out_reg
`timescale 1ns / 1ps
`default_nettype none

module bmp24_stream_decoder_unit #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire  [0:0]  req_tuser,   // [0] first_of_file
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // red, green, blue, image_width, image_height, zeros
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_pixel
);
   import bsd_pkg::*;

   req_item_type req_item, in_item;
   rsp_item_type res, out_item;
   pipe_ctl_type ctl;
   logic         in_valid, res_valid, advance, load;

   assign req_item.data_byte     = req_tdata;
   assign req_item.first_of_file = req_tuser[0];

   assign req_tready  = !in_valid || advance;
   assign load        = req_tvalid && req_tready;
   assign ctl.advance = advance;
   assign ctl.step    = advance && in_valid;

   bsd_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .advance (advance),
      .item    (req_item),
      .valid   (in_valid),
      .held    (in_item)
   );

   bsd_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (in_item),
      .res_valid (res_valid),
      .res       (res)
   );

   bsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .ready     (rsp_tready),
      .ctl       (ctl),
      .res_valid (res_valid),
      .res       (res),
      .valid     (rsp_tvalid),
      .advance   (advance),
      .held      (out_item)
   );

   assign rsp_tdata = {6'd0, out_item.image_height, out_item.image_width,
                       out_item.blue, out_item.green, out_item.red};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last_pixel;

endmodule

`default_nettype wire

[hw/rtl/bsd_checker.sv]
// bsd_checker: port-level checks on the decoder result channel, bound to the top level
// depends on bsd_pkg for the result kind codes
`timescale 1ns / 1ps
`default_nettype none

module bsd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [55:0] rsp_tdata,
   input wire [1:0]  rsp_tuser,
   input wire        rsp_tlast
);
   import bsd_pkg::*;

   // nothing is reported straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

   // only a pixel beat may close the image
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PIXEL)
      else $error("tlast on a beat that is not a pixel");

   // pixel beats carry no dimensions, other beats carry no colour
   a_fields_by_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_PIXEL && rsp_tdata[55:24] == 32'd0)
                  || (rsp_tuser == KIND_HEADER && rsp_tdata[55:50] == 6'd0
                      && rsp_tdata[23:0] == 24'd0)
                  || (rsp_tdata == 56'd0))
      else $error("result fields do not match the beat kind");

   // a stalled beat holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                 && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

endmodule

bind bmp24_stream_decoder_unit bsd_checker u_bsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for bmp24_stream_decoder_unit, bitmap files in, pixel, header and error beats out
// a local decoder model predicts every beat; depends on bsd_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb;
   import bsd_pkg::*;

   localparam int MAX_DIM     = 4096;
   localparam int CYCLE_LIMIT = 60000;
   localparam int HDR_BYTES   = 54;

   typedef enum int {SIG_INTACT, SIG_BAD_FIRST, SIG_BAD_SECOND} sig_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // decoder model state
   phase_type   dec_phase;
   logic [5:0]  hdr_offset;
   logic [31:0] width_acc, height_acc, col_idx, row_idx;
   logic [1:0]  chan_idx, pad_remaining;
   logic [7:0]  blue_hold, green_hold;

   rsp_item_type decoded_q[$];
   int          error_count = 0;
   int unsigned beats_seen = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_len = 0;

   bmp24_stream_decoder_unit #(.MAX_DIM(MAX_DIM)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit dim_bad(input logic [31:0] v);
      return v == 0 || v > MAX_DIM;
   endfunction

   function automatic logic [7:0] other_than(input logic [7:0] v);
      logic [7:0] r;
      r = 8'($urandom_range(255));
      if (r == v) r = ~v;
      return r;
   endfunction

   task automatic clear_decoder();
      dec_phase     = PH_IDLE;
      hdr_offset    = '0;
      width_acc     = '0;
      height_acc    = '0;
      col_idx       = '0;
      row_idx       = '0;
      chan_idx      = '0;
      pad_remaining = '0;
      blue_hold     = '0;
      green_hold    = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic first);
      rsp_item_type r;
      logic [5:0]   pos;
      r = '0;
      if (first) begin
         clear_decoder();
         dec_phase = PH_HEADER;
      end
      case (dec_phase)
         PH_HEADER: begin
            pos = hdr_offset;
            if ((pos == SIG_FIRST_POS && b != SIG_FIRST) ||
                (pos == SIG_SECOND_POS && b != SIG_SECOND)) begin
               dec_phase = PH_DONE;
               r.kind = KIND_NOT_BMP;
               decoded_q.push_back(r);
            end else begin
               if (pos >= WIDTH_POS && pos < HEIGHT_POS)
                  width_acc[8*(pos-WIDTH_POS) +: 8] = b;
               else if (pos >= HEIGHT_POS && pos < HEIGHT_END)
                  height_acc[8*(pos-HEIGHT_POS) +: 8] = b;
               if (pos != HDR_LAST_POS) begin
                  hdr_offset = pos + 6'd1;
               end else if (dim_bad(width_acc) || dim_bad(height_acc)) begin
                  dec_phase = PH_DONE;
                  r.kind = KIND_OVERSIZE;
                  decoded_q.push_back(r);
               end else begin
                  dec_phase = PH_PIXELS;
                  col_idx = '0;
                  row_idx = '0;
                  chan_idx = '0;
                  r.kind = KIND_HEADER;
                  r.image_width = width_acc[12:0];
                  r.image_height = height_acc[12:0];
                  decoded_q.push_back(r);
               end
            end
         end
         PH_PIXELS: begin
            if (chan_idx == 2'd0) begin
               blue_hold = b;
               chan_idx = 2'd1;
            end else if (chan_idx == 2'd1) begin
               green_hold = b;
               chan_idx = 2'd2;
            end else begin
               chan_idx = 2'd0;
               r.kind = KIND_PIXEL;
               r.red = b;
               r.green = green_hold;
               r.blue = blue_hold;
               col_idx++;
               if (col_idx >= width_acc) begin
                  col_idx = '0;
                  row_idx++;
                  pad_remaining = width_acc[1:0];
                  if (row_idx >= height_acc) begin
                     r.last_pixel = 1'b1;
                     dec_phase = PH_DONE;
                  end else if (pad_remaining != 2'd0) begin
                     dec_phase = PH_PAD;
                  end
               end
               decoded_q.push_back(r);
            end
         end
         PH_PAD: begin
            if (pad_remaining > 2'd0) pad_remaining--;
            if (pad_remaining == 2'd0) dec_phase = PH_PIXELS;
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string what, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   task automatic check_beat();
      rsp_item_type want;
      beats_seen++;
      if (decoded_q.size() == 0) begin
         $display("%0t: unexpected beat, expected none, actual kind %0d data %h last %0d",
                  $time, rsp_tuser, rsp_tdata, rsp_tlast);
         error_count++;
      end else begin
         want = decoded_q.pop_front();
         compare_field("kind", want.kind, rsp_tuser);
         compare_field("red", want.red, rsp_tdata[7:0]);
         compare_field("green", want.green, rsp_tdata[15:8]);
         compare_field("blue", want.blue, rsp_tdata[23:16]);
         compare_field("image_width", want.image_width, rsp_tdata[36:24]);
         compare_field("image_height", want.image_height, rsp_tdata[49:37]);
         compare_field("last_pixel", want.last_pixel, rsp_tlast);
      end
   endtask

   // both channels sampled at the rising edge, before any update lands
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tuser[0]);
      end
   end

   // consumer side: random stalls, or a long hold when asked for
   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one file: header, rows of bgr triples plus pad, optionally cut short, then junk
   task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                            input sig_fault_type fault, input int cut, input int tail,
                            input bit extreme);
      logic [7:0]  stream[$];
      logic [7:0]  b;
      int unsigned limit_len;
      limit_len = (cut < 0) ? 32'hFFFF_FFFF : cut;
      for (int i = 0; i < HDR_BYTES; i++) begin
         b = 8'($urandom_range(255));
         if (i == SIG_FIRST_POS) b = SIG_FIRST;
         else if (i == SIG_SECOND_POS) b = SIG_SECOND;
         else if (i >= WIDTH_POS && i < HEIGHT_POS) b = w[8*(i-WIDTH_POS) +: 8];
         else if (i >= HEIGHT_POS && i < HEIGHT_END) b = h[8*(i-HEIGHT_POS) +: 8];
         stream.push_back(b);
      end
      if (fault == SIG_BAD_FIRST) stream[SIG_FIRST_POS] = other_than(SIG_FIRST);
      if (fault == SIG_BAD_SECOND) stream[SIG_SECOND_POS] = other_than(SIG_SECOND);
      if (!dim_bad(w) && !dim_bad(h)) begin
         for (int r = 0; r < h && stream.size() < limit_len; r++) begin
            for (int c = 0; c < 3*w; c++)
               stream.push_back(extreme ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                        : 8'($urandom_range(255)));
            for (int p = 0; p < w[1:0]; p++) stream.push_back(8'($urandom_range(255)));
         end
      end
      while (stream.size() > limit_len) void'(stream.pop_back());
      repeat (tail) stream.push_back(8'($urandom_range(255)));
      bytes_sent += stream.size();
      foreach (stream[k]) send_byte(stream[k], k == 0);
   endtask

   task automatic test_stray_bytes();
      send_byte(SIG_FIRST, 1'b0);
      send_byte(SIG_SECOND, 1'b0);
      repeat (4) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic test_signature();
      send_file(2, 2, SIG_BAD_FIRST, 6, 2, 1'b0);
      send_file(2, 2, SIG_BAD_SECOND, 6, 2, 1'b0);
   endtask

   task automatic test_oversize();
      send_file(0, 1, SIG_INTACT, -1, 0, 1'b0);
      send_file(1, 0, SIG_INTACT, -1, 0, 1'b0);
      send_file(MAX_DIM + 1, 1, SIG_INTACT, -1, 0, 1'b0);
      send_file(1, MAX_DIM + 1, SIG_INTACT, -1, 2, 1'b0);
   endtask

   // pad lengths across a row change, the widest row and the tallest image cut short
   task automatic test_shapes();
      send_file(2, 2, SIG_INTACT, -1, 0, 1'b1);
      send_file(3, 2, SIG_INTACT, -1, 0, 1'b0);
      send_file(4, MAX_DIM, SIG_INTACT, HDR_BYTES + 30, 0, 1'b0);
      send_file(MAX_DIM, 1, SIG_INTACT, HDR_BYTES + 12, 0, 1'b0);
   endtask

   task automatic test_restart();
      send_file(3, 3, SIG_INTACT, 10, 0, 1'b0);
      send_file(7, 3, SIG_INTACT, HDR_BYTES + 4, 0, 1'b0);
      send_file(2, 1, SIG_INTACT, -1, 0, 1'b0);
   endtask

   task automatic test_trailing_bytes();
      send_file(1, 2, SIG_INTACT, -1, 6, 1'b0);
   endtask

   task automatic test_random_files();
      int unsigned byte_mark, beat_mark, pick;
      logic [31:0] w, h;
      byte_mark = bytes_sent;
      beat_mark = beats_seen;
      while (bytes_sent - byte_mark < 40 || beats_seen - beat_mark < 2) begin
         pick = $urandom_range(99);
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         if (pick < 70) begin
            send_file(w, h, SIG_INTACT, -1, $urandom_range(0, 3), $urandom_range(9) == 0);
         end else if (pick < 80) begin
            send_file(w, h, SIG_INTACT, $urandom_range(1, 90), 0, 1'b0);
         end else if (pick < 87) begin
            send_file(w, h, $urandom_range(1) ? SIG_BAD_FIRST : SIG_BAD_SECOND, -1,
                      $urandom_range(0, 4), 1'b0);
         end else if (pick < 94) begin
            if ($urandom_range(1)) w = $urandom_range(2) == 0 ? 32'd0 : $urandom;
            else h = $urandom_range(2) == 0 ? 32'd0 : $urandom;
            if (!dim_bad(w) && !dim_bad(h)) h = 0;
            send_file(w, h, SIG_INTACT, -1, $urandom_range(0, 4), 1'b0);
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
         end
         // let the consumer catch up now and then so queue depth varies
         if ($urandom_range(3) == 0) wait_drained();
      end
   endtask

   // consumer holds off while the producer keeps pushing a full image
   task automatic test_backpressure();
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len = 250;
      send_file(2, 2, SIG_INTACT, -1, 2, 1'b0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_stray_bytes();
      test_signature();
      test_oversize();
      test_shapes();
      test_restart();
      test_trailing_bytes();
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin sender_idle_pct = 17; rsp_stall_pct = 17; end
         endcase
         test_random_files();
         wait_drained();
      end

      test_backpressure();
      wait_drained();

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
